// ===== sv/double_ended_queue_unit_assert.svh =====
// Assertion macros for the double-ended queue unit checker.
// Depends on nothing; expects clk and rst to be visible where it is used.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DQU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DQU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dqu_pkg.sv =====
// Shared types and codes for the double-ended queue unit.
// Depends on nothing; used by every module of the block except dqu_ram.
package dqu_pkg;

  localparam int OP_W      = 3;
  localparam int VALUE_W   = 32;
  localparam int INDEX_W   = 6;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 2;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_PUSH_BACK  = 3'd0;
  localparam op_t OP_PUSH_FRONT = 3'd1;
  localparam op_t OP_POP_FRONT  = 3'd2;
  localparam op_t OP_POP_BACK   = 3'd3;
  localparam op_t OP_READ       = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  typedef struct packed {
    logic latch;
    logic exec;
    logic load;
  } dqu_cmd_t;

endpackage

// ===== sv/dqu_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module dqu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/dqu_ctrl.sv =====
// Controller state machine for the double-ended queue unit.
// Depends on dqu_pkg; drives the datapath through dqu_cmd_t.
module dqu_ctrl import dqu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output dqu_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign s_tready  = (state == S_IDLE) && !rst;
  assign out_free  = !m_tvalid || m_tready;
  assign cmd.latch = s_tvalid && s_tready;
  assign cmd.exec  = (state == S_EXEC);
  assign cmd.load  = (state == S_RESULT) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.latch) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/dqu_datapath.sv =====
// Datapath of the double-ended queue unit: ring pointers, entry RAM and result register.
// Depends on dqu_pkg and dqu_ram; sequenced by dqu_ctrl.
module dqu_datapath import dqu_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dqu_cmd_t             cmd,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  op_t                  s_tuser,
  output logic [M_TDATA_W-1:0] m_tdata,
  output status_t              m_tuser
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;

  op_t                  req_op;
  logic [VALUE_W-1:0]   req_value;
  logic [INDEX_W-1:0]   req_index;
  logic [AW-1:0]        head;
  logic [AW-1:0]        head_next;
  logic [CW-1:0]        fill;
  logic [CW-1:0]        fill_next;
  status_t              status_next;
  logic                 take_next;
  logic                 take_data;
  status_t              res_status;
  logic [COUNT_W-1:0]   res_count;
  logic [COUNT_W-1:0]   count_next;
  logic [DATA_W-1:0]    out_data;
  logic [COUNT_W-1:0]   out_count;
  status_t              out_status;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [DATA_WIDTH-1:0] wr_word;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [DATA_W-1:0]    rd_ext;
  logic [SW-1:0]        head_ext;
  logic [SW-1:0]        fill_ext;
  logic [SW-1:0]        idx_ext;
  logic [AW-1:0]        head_dec;
  logic [AW-1:0]        head_inc;
  logic                 is_full;
  logic                 is_empty;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] x);
    logic [SW-1:0] y;
    y = (x >= SW'(DEPTH)) ? (x - SW'(DEPTH)) : x;
    return y[AW-1:0];
  endfunction

  assign head_ext = SW'(head);
  assign fill_ext = SW'(fill);
  assign idx_ext  = SW'(req_index);
  assign is_full  = (fill == CW'(DEPTH));
  assign is_empty = (fill == '0);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : (head - 1'b1);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : (head + 1'b1);

  generate
    if (DATA_WIDTH <= VALUE_W) begin : g_wr_narrow
      assign wr_word = req_value[DATA_WIDTH-1:0];
    end else begin : g_wr_wide
      assign wr_word = {{(DATA_WIDTH-VALUE_W){1'b0}}, req_value};
    end
    if (DATA_WIDTH >= DATA_W) begin : g_rd_wide
      assign rd_ext = rd_word[DATA_W-1:0];
    end else begin : g_rd_narrow
      assign rd_ext = {{(DATA_W-DATA_WIDTH){1'b0}}, rd_word};
    end
    if (CW >= COUNT_W) begin : g_cnt_wide
      assign count_next = fill_next[COUNT_W-1:0];
    end else begin : g_cnt_narrow
      assign count_next = {{(COUNT_W-CW){1'b0}}, fill_next};
    end
  endgenerate

  always_comb begin
    head_next   = head;
    fill_next   = fill;
    wr_en       = 1'b0;
    wr_addr     = wrap(head_ext + fill_ext);
    rd_addr     = head;
    status_next = ST_OK;
    take_next   = 1'b0;
    case (req_op)
      OP_PUSH_BACK: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          fill_next = fill + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = head_dec;
          head_next = head_dec;
          fill_next = fill + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          rd_addr   = head;
          head_next = head_inc;
          fill_next = fill - 1'b1;
          take_next = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          rd_addr   = wrap(head_ext + fill_ext - 1'b1);
          fill_next = fill - 1'b1;
          take_next = 1'b1;
        end
      end
      OP_READ: begin
        if (idx_ext >= fill_ext) begin
          status_next = ST_RANGE;
        end else begin
          rd_addr   = wrap(head_ext + idx_ext);
          take_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  dqu_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec && wr_en),
    .waddr (wr_addr),
    .wdata (wr_word),
    .re    (cmd.exec),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (cmd.exec) begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_op    <= s_tuser;
      req_value <= s_tdata[VALUE_W-1:0];
      req_index <= s_tdata[VALUE_W+INDEX_W-1:VALUE_W];
    end
    if (cmd.exec) begin
      res_status <= status_next;
      res_count  <= count_next;
      take_data  <= take_next;
    end
    if (cmd.load) begin
      out_data   <= take_data ? rd_ext : '0;
      out_count  <= res_count;
      out_status <= res_status;
    end
  end

  assign m_tdata = {{(M_TDATA_W-DATA_W-COUNT_W){1'b0}}, out_count, out_data};
  assign m_tuser = out_status;

endmodule

// ===== sv/double_ended_queue_unit.sv =====
// Top level of the double-ended queue unit with random read access.
// Depends on dqu_pkg, dqu_ctrl and dqu_datapath.
//
// Channel  Direction  Contents
// s_*      in         tuser: operation; tdata: value, index
// m_*      out        tdata: data, count; tuser: status
//
// Each request passes in turn through capture, ring update with one RAM access, and result load.
// A new request is taken only after the previous result is loaded; the controller state machine sets this.
// A result waiting on m_tready holds the next request in the controller until it is taken.
// Reset clears the head pointer and fill count; entry contents stay undefined until written.
// s_tready is low while reset is high.
module double_ended_queue_unit import dqu_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // value[31:0], index[37:32], zero fill
  input  op_t                  s_tuser,  // operation[2:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // data[31:0], count[38:32], zero fill
  output status_t              m_tuser   // status[1:0]
);

  dqu_cmd_t cmd;

  dqu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  dqu_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

// ===== sv/dqu_checker.sv =====
// Port-level checker for the double-ended queue unit, bound to the top level.
// Depends on dqu_pkg and double_ended_queue_unit_assert.svh.
`include "double_ended_queue_unit_assert.svh"

module dqu_checker import dqu_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input status_t              m_tuser
);

  `DQU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `DQU_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second request taken while one is in progress")
  `DQU_ASSERT_NOW(a_error_no_data, m_tvalid && (m_tuser != ST_OK), m_tdata[DATA_W-1:0] == '0, "failed request returned data")
  `DQU_ASSERT_NOW(a_empty_count, m_tvalid && (m_tuser == ST_EMPTY), m_tdata[DATA_W+COUNT_W-1:DATA_W] == '0, "empty status with nonzero count")
  `DQU_ASSERT_NOW(a_full_count, m_tvalid && (m_tuser == ST_FULL), m_tdata[DATA_W+COUNT_W-1:DATA_W] == COUNT_W'(DEPTH), "full status with wrong count")

endmodule

bind double_ended_queue_unit dqu_checker #(
  .DEPTH (DEPTH)
) u_dqu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
